// ===== src/m2cn_pkg.sv =====
// ----------------------------------------------------------------------------
// 2x2 condition number package
// Shared widths and stage payload types for the condition number pipeline.
// ----------------------------------------------------------------------------
package m2cn_pkg;

    localparam int ELEM_W  = 16;
    localparam int SQ_W    = 32;
    localparam int TRACE_W = 34;
    localparam int DET_W   = 33;
    localparam int TWOD_W  = 33;
    localparam int DISC_W  = 70;
    localparam int ROOT_W  = 35;
    localparam int COND_W  = 32;

    typedef struct packed {
        logic [TRACE_W-1:0] trace;
        logic [TWOD_W-1:0]  two_det;
        logic               singular;
    } m2cn_front_t;

endpackage

// ===== src/m2cn_front.sv =====
// ----------------------------------------------------------------------------
// 2x2 condition number front end
// Squares and cross products in one stage, then trace and twice the
// absolute determinant in the next.
// ----------------------------------------------------------------------------
module m2cn_front
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [m2cn_pkg::ELEM_W-1:0] a,
    input  logic signed [m2cn_pkg::ELEM_W-1:0] b,
    input  logic signed [m2cn_pkg::ELEM_W-1:0] c,
    input  logic signed [m2cn_pkg::ELEM_W-1:0] d,
    output logic                            out_valid,
    output m2cn_pkg::m2cn_front_t           out_data
);

    logic        v1_reg, v2_reg;
    logic [31:0] aa_reg, bb_reg, cc_reg, dd_reg;
    logic signed [31:0] ad_reg, bc_reg;
    m2cn_pkg::m2cn_front_t data_reg, data_next;
    logic signed [32:0] det;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        aa_reg   <= a * a;
        bb_reg   <= b * b;
        cc_reg   <= c * c;
        dd_reg   <= d * d;
        ad_reg   <= a * d;
        bc_reg   <= b * c;
        data_reg <= data_next;
    end

    always_comb
    begin
        det = 33'(ad_reg) - 33'(bc_reg);
        data_next.trace = {2'b00, aa_reg} + {2'b00, bb_reg}
                        + {2'b00, cc_reg} + {2'b00, dd_reg};
        data_next.two_det = det[32] ? 33'(-det) << 1 : 33'(det) << 1;
        data_next.singular = (det == '0);
    end

    assign out_valid = v2_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/m2cn_sqrt.sv =====
// ----------------------------------------------------------------------------
// 2x2 condition number root pipeline
// Forms the discriminant product and extracts its integer square root one
// result bit per stage.
// ----------------------------------------------------------------------------
module m2cn_sqrt
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  m2cn_pkg::m2cn_front_t in_data,
    output logic                  out_valid,
    output m2cn_pkg::m2cn_front_t out_data,
    output logic [m2cn_pkg::ROOT_W-1:0] root
);

    localparam int RW = m2cn_pkg::ROOT_W;
    localparam int DW = m2cn_pkg::DISC_W;

    // Product of the two factors is split into four partial products of 18-bit and 17-bit halves.
    logic               p_valid_reg;
    m2cn_pkg::m2cn_front_t p_data_reg;
    logic [34:0]        lo_fac, hi_fac;
    logic [35:0]        diff;
    logic [35:0]        ll_reg, lh_reg, hl_reg, hh_reg;
    logic               q_valid_reg;
    m2cn_pkg::m2cn_front_t q_data_reg;
    logic [DW-1:0]      q_disc_reg;

    logic [RW:0]        v_reg;
    m2cn_pkg::m2cn_front_t s_data_reg [RW+1];
    logic [DW-1:0]      s_rem_reg  [RW+1];
    logic [RW-1:0]      s_root_reg [RW+1];

    always_comb
    begin
        diff   = {2'b00, in_data.trace} - {3'b000, in_data.two_det};
        lo_fac = diff[35] ? '0 : diff[34:0];
        hi_fac = {1'b0, in_data.trace} + {2'b00, in_data.two_det};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            q_valid_reg <= 1'b0;
            v_reg       <= '0;
        end
        else
        begin
            p_valid_reg <= in_valid;
            q_valid_reg <= p_valid_reg;
            v_reg       <= {v_reg[RW-1:0], q_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        p_data_reg <= in_data;
        ll_reg <= {18'd0, lo_fac[17:0]} * {18'd0, hi_fac[17:0]};
        lh_reg <= {18'd0, lo_fac[17:0]} * {19'd0, hi_fac[34:18]};
        hl_reg <= {19'd0, lo_fac[34:18]} * {18'd0, hi_fac[17:0]};
        hh_reg <= {19'd0, lo_fac[34:18]} * {19'd0, hi_fac[34:18]};
        q_data_reg <= p_data_reg;
        q_disc_reg <= DW'(ll_reg) + (DW'(lh_reg) << 18) + (DW'(hl_reg) << 18)
                    + (DW'(hh_reg) << 36);
        s_data_reg[0] <= q_data_reg;
        s_rem_reg[0]  <= q_disc_reg;
        s_root_reg[0] <= '0;
    end

    // Restoring square root: stage k decides result bit RW-1-k.
    for (genvar k = 0; k < RW; k++) begin : g_bit
        localparam int BIT = RW - 1 - k;
        logic [DW+1:0] trial;
        logic [DW+1:0] rem_ext;
        always_comb
        begin
            trial = ((DW+2)'(s_root_reg[k]) << (BIT + 1)) + ((DW+2)'(1) << (2 * BIT));
            rem_ext = (DW+2)'(s_rem_reg[k]);
        end
        always_ff @(posedge clk)
        begin
            s_data_reg[k+1] <= s_data_reg[k];
            if (rem_ext >= trial)
            begin
                s_rem_reg[k+1]  <= DW'(rem_ext - trial);
                s_root_reg[k+1] <= s_root_reg[k] | (RW'(1) << BIT);
            end
            else
            begin
                s_rem_reg[k+1]  <= s_rem_reg[k];
                s_root_reg[k+1] <= s_root_reg[k];
            end
        end
    end

    assign out_valid = v_reg[RW];
    assign out_data  = s_data_reg[RW];
    assign root      = s_root_reg[RW];

endmodule

// ===== src/m2cn_div.sv =====
// ----------------------------------------------------------------------------
// 2x2 condition number divider
// Pipelined restoring division of the scaled eigenvalue sum by twice the
// absolute determinant, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
module m2cn_div
#(
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  m2cn_pkg::m2cn_front_t            in_data,
    input  logic [m2cn_pkg::ROOT_W-1:0]      root,
    output logic                             out_valid,
    output logic [m2cn_pkg::COND_W-1:0]      cond_value,
    output logic                             singular,
    output logic                             saturated
);

    localparam int SUM_W = m2cn_pkg::TRACE_W + 1;
    localparam int NUM_W = SUM_W + OUT_FRAC_BITS;
    localparam int QW    = NUM_W;
    localparam int DVW   = m2cn_pkg::TWOD_W;
    localparam int CW    = m2cn_pkg::COND_W;

    logic [QW:0]      v_reg;
    logic [NUM_W-1:0] n_reg  [QW+1];
    logic [DVW-1:0]   d_reg  [QW+1];
    logic [DVW:0]     r_reg  [QW+1];
    logic [QW-1:0]    q_reg  [QW+1];
    logic             s_reg  [QW+1];
    logic [CW-1:0]    cond_reg, cond_next;
    logic             sing_reg, sat_reg, sat_next;
    logic             ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            v_reg  <= {v_reg[QW-1:0], in_valid};
            ov_reg <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg[0] <= NUM_W'(SUM_W'(in_data.trace) + SUM_W'(root)) << OUT_FRAC_BITS;
        d_reg[0] <= in_data.two_det;
        r_reg[0] <= '0;
        q_reg[0] <= '0;
        s_reg[0] <= in_data.singular;
    end

    for (genvar k = 0; k < QW; k++) begin : g_bit
        logic [DVW:0] shifted;
        always_comb
        begin
            shifted = {r_reg[k][DVW-1:0], n_reg[k][NUM_W-1-k]};
        end
        always_ff @(posedge clk)
        begin
            n_reg[k+1] <= n_reg[k];
            d_reg[k+1] <= d_reg[k];
            s_reg[k+1] <= s_reg[k];
            if (shifted >= {1'b0, d_reg[k]})
            begin
                r_reg[k+1] <= shifted - {1'b0, d_reg[k]};
                q_reg[k+1] <= {q_reg[k][QW-2:0], 1'b1};
            end
            else
            begin
                r_reg[k+1] <= shifted;
                q_reg[k+1] <= {q_reg[k][QW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        sat_next  = 1'b0;
        cond_next = q_reg[QW][CW-1:0];
        if (s_reg[QW])
        begin
            cond_next = '0;
        end
        else if (q_reg[QW][QW-1:CW] != '0)
        begin
            cond_next = '1;
            sat_next  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        cond_reg <= cond_next;
        sing_reg <= s_reg[QW];
        sat_reg  <= sat_next;
    end

    assign out_valid  = ov_reg;
    assign cond_value = cond_reg;
    assign singular   = sing_reg;
    assign saturated  = sat_reg;

endmodule

// ===== src/matrix2_condition_number_core.sv =====
// ----------------------------------------------------------------------------
// 2x2 matrix condition number core
// Streams one 2x2 matrix per cycle and returns its 2-norm condition number.
// ----------------------------------------------------------------------------
// Raise start with the four Q8.8 elements in column-major order; a word is
// taken at every edge where start is high and busy is low. Busy is low while
// IN_FRAC_BITS is non-negative, so a new matrix may enter every cycle.
// Each result appears on cond_value, singular and saturated for one cycle
// with done high. Each matrix passes in turn through the products and trace,
// the discriminant product and root setup, the bit-serial square root stages
// and the division stages, then through one output register.
// Throughput is one matrix per cycle; results leave in input order.
// The receiver cannot stall, so there is no back pressure anywhere.
// Reset clears all valid bits, so no done pulse follows reset until a new
// matrix enters. Singular matrices give zero with singular set; quotients
// beyond 32 bits give all ones with saturated set.
// ----------------------------------------------------------------------------
module matrix2_condition_number_core
#(
    parameter int IN_FRAC_BITS  = 8,
    parameter int OUT_FRAC_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  elem_c0_r0,
    input  logic signed [15:0]  elem_c0_r1,
    input  logic signed [15:0]  elem_c1_r0,
    input  logic signed [15:0]  elem_c1_r1,
    output logic                done,
    output logic [31:0]         cond_value,
    output logic                singular,
    output logic                saturated
);

    logic                  f_valid, r_valid;
    m2cn_pkg::m2cn_front_t f_data, r_data;
    logic [m2cn_pkg::ROOT_W-1:0] root;
    logic                  accept;

    // The input scale cancels in the ratio; it only bounds the element format.
    assign busy   = (IN_FRAC_BITS < 0);
    assign accept = start && !busy;

    m2cn_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .a         (elem_c0_r0),
        .b         (elem_c0_r1),
        .c         (elem_c1_r0),
        .d         (elem_c1_r1),
        .out_valid (f_valid),
        .out_data  (f_data)
    );

    m2cn_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_data   (f_data),
        .out_valid (r_valid),
        .out_data  (r_data),
        .root      (root)
    );

    m2cn_div #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_div
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (r_valid),
        .in_data    (r_data),
        .root       (root),
        .out_valid  (done),
        .cond_value (cond_value),
        .singular   (singular),
        .saturated  (saturated)
    );

endmodule

// ===== src/m2cn_checker.sv =====
// ----------------------------------------------------------------------------
// 2x2 condition number port checker
// Checks result flags, output consistency, busy and done after reset at the top-level ports.
// ----------------------------------------------------------------------------
module m2cn_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [31:0] cond_value,
    input logic        singular,
    input logic        saturated
);

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(singular && saturated))
        else $error("singular and saturated both set");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && singular |-> cond_value == 32'd0)
        else $error("singular result is not zero");

    a_saturated_max: assert property (@(posedge clk) disable iff (!rst_n)
        done && saturated |-> cond_value == 32'hFFFF_FFFF)
        else $error("saturated result is not all ones");

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("core refused a word");

    a_no_result_after_reset: assert property (@(posedge clk)
        !rst_n |=> !done)
        else $error("result right after reset");

endmodule

bind matrix2_condition_number_core m2cn_checker u_m2cn_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .cond_value (cond_value),
    .singular   (singular),
    .saturated  (saturated)
);
